FILE: rtl/pdcs_pkg.sv
// Shared types and constants of the path disc cost stamper.
package pdcs_pkg;

	// Fixed bounds of the stamp arithmetic
	localparam int MAX_RADIUS      = 15;
	localparam int MAX_PATH_POINTS = 1024;

	// Configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// Register reset values
	localparam logic       ENABLE_RST  = 1'b1;
	localparam logic [7:0] PEAK_RST    = 8'd200;
	localparam logic [7:0] TAIL_RST    = 8'd80;
	localparam logic [3:0] RADIUS_RST  = 4'd1;
	localparam logic [8:0] WIN_LO_RST  = 9'd0;
	localparam logic [8:0] WIN_HI_RST  = 9'd256;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 3'd0,
		REG_PEAK      = 3'd1,
		REG_TAIL      = 3'd2,
		REG_RADIUS    = 3'd3,
		REG_WIN_LO_X  = 3'd4,
		REG_WIN_LO_Y  = 3'd5,
		REG_WIN_HI_X  = 3'd6,
		REG_WIN_HI_Y  = 3'd7
	} cfg_reg_t;

	// Input item
	typedef struct packed {
		logic        func;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic        in_map;
		logic [9:0]  point_index;
		logic [10:0] path_length;
	} stamp_req_t;

	// Result item
	typedef struct packed {
		logic [7:0] stamp_cost;
		logic [9:0] cells_written;
		logic [7:0] cell_cost;
	} stamp_rsp_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV,
		ST_SCAN,
		ST_DRAIN,
		ST_RD_ISSUE,
		ST_RD_CAP,
		ST_FIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic div_step;
		logic scan_step;
		logic clr_step;
		logic rd_cap;
		logic res_load;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_read;
		logic is_skip;
		logic div_last;
		logic scan_last;
		logic clr_last;
	} ctrl_sts_t;

endpackage

FILE: rtl/pdcs_if.sv
// Channel interfaces: stamp requests, results and configuration writes.
interface pdcs_cmd_if;
	import pdcs_pkg::*;
	logic       valid;
	logic       ready;
	stamp_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pdcs_rsp_if;
	import pdcs_pkg::*;
	logic       valid;
	logic       ready;
	stamp_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pdcs_cfg_if;
	import pdcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink (input valid, input idx, input wdata, output ready);
endinterface

FILE: rtl/pdcs_grid.sv
// Cost grid memory: one write port, one read port with registered data.
module pdcs_grid #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);
	logic [7:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/pdcs_ctrl.sv
// Controller state machine of the stamper: sequences clear, cost, scan and read.
module pdcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  pdcs_pkg::ctrl_sts_t  sts,
	output pdcs_pkg::ctrl_cmd_t  cmd
);
	import pdcs_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:    if (sts.clr_last) state_nxt = ST_IDLE;
			ST_IDLE:     if (cmd_valid) state_nxt = ST_DECODE;
			ST_DECODE: begin
				if (sts.is_read) state_nxt = ST_RD_ISSUE;
				else if (sts.is_skip) state_nxt = ST_FIN;
				else state_nxt = ST_MUL_A;
			end
			ST_MUL_A:    state_nxt = ST_MUL_B;
			ST_MUL_B:    state_nxt = ST_DIV;
			ST_DIV:      if (sts.div_last) state_nxt = ST_SCAN;
			ST_SCAN:     if (sts.scan_last) state_nxt = ST_DRAIN;
			ST_DRAIN:    state_nxt = ST_FIN;
			ST_RD_ISSUE: state_nxt = ST_RD_CAP;
			ST_RD_CAP:   state_nxt = ST_FIN;
			ST_FIN:      if (out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd_ready = 1'b1;
				cmd.load  = cmd_valid;
			end
			ST_MUL_A:  cmd.mul_a = 1'b1;
			ST_MUL_B:  cmd.mul_b = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_RD_CAP: cmd.rd_cap = 1'b1;
			ST_FIN:    cmd.res_load = out_free;
			default:   cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set on a new result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/pdcs_datapath.sv
// Datapath: config registers, point cost divider, disc scanner and grid access.
module pdcs_datapath #(
	parameter int GRID_WIDTH  = 256,
	parameter int GRID_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pdcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  pdcs_pkg::stamp_req_t            req,
	input  pdcs_pkg::ctrl_cmd_t             cmd,
	output pdcs_pkg::ctrl_sts_t             sts,
	output pdcs_pkg::stamp_rsp_t            rsp
);
	import pdcs_pkg::*;

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers
	logic       enable_q;
	logic [7:0] peak_q;
	logic [7:0] tail_q;
	logic [3:0] radius_q;
	logic [8:0] lo_x_q, lo_y_q, hi_x_q, hi_y_q;

	// Item registers
	logic          rd_q, act_q, one_pt_q, rd_ok_q;
	logic [7:0]    cx_q, cy_q;
	logic [10:0]   den_q, idx_q;
	logic [AW-1:0] rd_addr_q;

	// Cost arithmetic
	logic [18:0] prod_q;
	logic [11:0] rem_q;
	logic [7:0]  dlo_q, quot_q;
	logic [2:0]  div_cnt_q;
	logic [7:0]  cost;

	// Scanner and pipeline
	logic [3:0]        r_q;
	logic [7:0]        r2_q;
	logic signed [4:0] dx_q, dy_q;
	logic              valid_s1;
	logic [AW-1:0]     addr_s1;
	logic [9:0]        cnt_q;
	logic [7:0]        rcost_q;
	logic [AW-1:0]     clr_q;

	// Grid ports
	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	logic [7:0]    mem_rd_data, mem_wr_data;
	logic          mem_wr_en;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			peak_q   <= PEAK_RST;
			tail_q   <= TAIL_RST;
			radius_q <= RADIUS_RST;
			lo_x_q   <= WIN_LO_RST;
			lo_y_q   <= WIN_LO_RST;
			hi_x_q   <= WIN_HI_RST;
			hi_y_q   <= WIN_HI_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ENABLE:   enable_q <= cfg_wdata[0];
				REG_PEAK:     peak_q   <= cfg_wdata[7:0];
				REG_TAIL:     tail_q   <= cfg_wdata[7:0];
				REG_RADIUS:   radius_q <= cfg_wdata[3:0];
				REG_WIN_LO_X: lo_x_q   <= cfg_wdata;
				REG_WIN_LO_Y: lo_y_q   <= cfg_wdata;
				REG_WIN_HI_X: hi_x_q   <= cfg_wdata;
				REG_WIN_HI_Y: hi_y_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decode the incoming item
	logic [10:0] len_sat, den_in, idx_in;
	logic [3:0]  r_in;
	always_comb begin
		len_sat = (32'(req.path_length) > MAX_PATH_POINTS) ? 11'(MAX_PATH_POINTS)
		                                                  : req.path_length;
		den_in  = len_sat - 11'd1;
		idx_in  = ({1'b0, req.point_index} > den_in) ? den_in : {1'b0, req.point_index};
		if (radius_q == 4'd0) r_in = 4'd1;
		else if (32'(radius_q) > MAX_RADIUS) r_in = 4'(MAX_RADIUS);
		else r_in = radius_q;
	end

	// Hold the item and start the scanner
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q      <= req.func;
			act_q     <= !req.func && enable_q && req.in_map && (req.path_length != '0);
			one_pt_q  <= (len_sat <= 11'd1);
			den_q     <= den_in;
			idx_q     <= idx_in;
			cx_q      <= req.cell_x;
			cy_q      <= req.cell_y;
			rd_ok_q   <= (32'(req.cell_x) < GRID_WIDTH) && (32'(req.cell_y) < GRID_HEIGHT);
			rd_addr_q <= AW'(32'(req.cell_y) * 32'(GRID_WIDTH) + 32'(req.cell_x));
			r_q       <= r_in;
			r2_q      <= 8'(r_in * r_in);
			dx_q      <= -$signed({1'b0, r_in});
			dy_q      <= -$signed({1'b0, r_in});
		end else if (cmd.scan_step) begin
			if (dy_q == $signed({1'b0, r_q})) begin
				dy_q <= -$signed({1'b0, r_q});
				dx_q <= dx_q + 5'sd1;
			end else begin
				dy_q <= dy_q + 5'sd1;
			end
		end
	end

	// Point cost: peak * den, then subtract the slope term and round
	logic [7:0]  tail_eff, slope;
	logic [18:0] num;
	logic [20:0] dividend;
	logic [11:0] dvs;
	logic [12:0] trial;
	logic        ge;
	always_comb begin
		tail_eff = (tail_q < peak_q) ? tail_q : peak_q;
		slope    = peak_q - tail_eff;
		num      = prod_q - 19'(idx_q * slope);
		dividend = {1'b0, num, 1'b0} + 21'(den_q);
		dvs      = {den_q, 1'b0};
		trial    = {rem_q, dlo_q[7]};
		ge       = trial >= {1'b0, dvs};
		cost     = one_pt_q ? peak_q : quot_q;
	end

	// Restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			prod_q <= 19'(peak_q * den_q);
		end
		if (cmd.mul_b) begin
			rem_q     <= 12'(dividend >> 8);
			dlo_q     <= dividend[7:0];
			div_cnt_q <= 3'd0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? 12'(trial - {1'b0, dvs}) : trial[11:0];
			dlo_q     <= {dlo_q[6:0], 1'b0};
			quot_q    <= {quot_q[6:0], ge};
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	// Disc cell test and address
	logic [3:0]        adx, ady;
	logic [8:0]        dist2;
	logic signed [9:0] nx, ny;
	logic [8:0]        nxu, nyu;
	logic              cell_ok;
	logic [AW-1:0]     scan_addr;
	always_comb begin
		adx   = 4'(dx_q[4] ? -dx_q : dx_q);
		ady   = 4'(dy_q[4] ? -dy_q : dy_q);
		dist2 = 9'(adx * adx) + 9'(ady * ady);
		nx    = $signed({2'b00, cx_q}) + 10'(dx_q);
		ny    = $signed({2'b00, cy_q}) + 10'(dy_q);
		nxu   = nx[8:0];
		nyu   = ny[8:0];
		cell_ok = (dist2 <= {1'b0, r2_q}) && !nx[9] && !ny[9]
			&& (nxu >= lo_x_q) && (nxu < hi_x_q) && (nyu >= lo_y_q) && (nyu < hi_y_q)
			&& (32'(nxu) < GRID_WIDTH) && (32'(nyu) < GRID_HEIGHT);
		scan_addr = AW'(32'(nyu) * 32'(GRID_WIDTH) + 32'(nxu));
	end

	// Read stage to write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_step && cell_ok;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= scan_addr;
		if (cmd.load) begin
			cnt_q <= '0;
		end else if (valid_s1) begin
			cnt_q <= cnt_q + 10'd1;
		end
		if (cmd.rd_cap) begin
			rcost_q <= rd_ok_q ? mem_rd_data : 8'd0;
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Grid port selection
	always_comb begin
		mem_rd_addr = cmd.scan_step ? scan_addr : rd_addr_q;
		if (cmd.clr_step) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_q;
			mem_wr_data = 8'd0;
		end else begin
			mem_wr_en   = valid_s1;
			mem_wr_addr = addr_s1;
			mem_wr_data = (mem_rd_data > cost) ? mem_rd_data : cost;
		end
	end

	pdcs_grid #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_grid (
		.clk     (clk),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp.stamp_cost    <= act_q ? cost : 8'd0;
			rsp.cells_written <= act_q ? cnt_q : 10'd0;
			rsp.cell_cost     <= rd_q ? rcost_q : 8'd0;
		end
	end

	// Status
	assign sts.is_read   = rd_q;
	assign sts.is_skip   = !rd_q && !act_q;
	assign sts.div_last  = (div_cnt_q == 3'd7);
	assign sts.scan_last = (dx_q == $signed({1'b0, r_q})) && (dy_q == $signed({1'b0, r_q}));
	assign sts.clr_last  = (clr_q == AW'(DEPTH - 1));

endmodule

FILE: rtl/path_disc_cost_stamper.sv
// Path disc cost stamper: max-stamps path point costs as discs into a byte grid.
// Stamp: a restoring divide for the cost, then a disc scan doing one grid
//   read-modify-write per cycle. Read: issue, then capture. Skipped stamp:
//   straight to the result. One item in work at a time.
// Reset: configuration registers take their reset values, then a clearing pass
//   zeroes all GRID_WIDTH*GRID_HEIGHT grid cells; no item is taken during it.
module path_disc_cost_stamper #(
	parameter int GRID_WIDTH  = 256,
	parameter int GRID_HEIGHT = 256
) (
	input logic        clk,
	input logic        arst_n,
	pdcs_cmd_if.sink   cmd,
	pdcs_rsp_if.source rsp,
	pdcs_cfg_if.sink   cfg
);
	import pdcs_pkg::*;

	ctrl_cmd_t ctl_cmd;
	ctrl_sts_t ctl_sts;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	pdcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	pdcs_datapath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.idx),
		.cfg_wdata (cfg.wdata),
		.req       (cmd.data),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts),
		.rsp       (rsp.data)
	);

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the path disc cost stamper: random paths and reads checked against a cost map model.
module tb_top;
	import pdcs_pkg::*;

	localparam int GRID_W           = 256;
	localparam int GRID_H           = 256;
	localparam int STALL_LIMIT      = 200000;
	localparam int END_DRAIN_CYCLES = 1000;
	localparam int ITEMS_PER_PHASE  = 190;
	localparam int ITEMS_PER_SETUP  = 50;
	localparam int MAX_REPORTS      = 10;
	localparam logic FUNC_STAMP     = 1'b0;
	localparam logic FUNC_READ      = 1'b1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pdcs_cmd_if cmd_ch();
	pdcs_rsp_if rsp_ch();
	pdcs_cfg_if cfg_ch();

	path_disc_cost_stamper #(
		.GRID_WIDTH  (GRID_W),
		.GRID_HEIGHT (GRID_H)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Cost map model and register shadows
	bit   [7:0] cost_map [GRID_W*GRID_H];
	logic       en_r     = ENABLE_RST;
	logic [7:0] peak_r   = PEAK_RST;
	logic [7:0] tail_r   = TAIL_RST;
	logic [3:0] radius_r = RADIUS_RST;
	logic [8:0] win_lo_x = WIN_LO_RST;
	logic [8:0] win_lo_y = WIN_LO_RST;
	logic [8:0] win_hi_x = WIN_HI_RST;
	logic [8:0] win_hi_y = WIN_HI_RST;

	stamp_rsp_t reports_due [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int n_sent       = 0;
	int n_stamps     = 0;
	int n_skips      = 0;
	int n_reads      = 0;
	int n_checked    = 0;
	int n_cfg_writes = 0;
	int n_fail       = 0;
	int stall_cycles = 0;
	logic [7:0] last_x = '0;
	logic [7:0] last_y = '0;

	// Linear cost along the path, rounded half up
	function automatic logic [7:0] path_point_cost(logic [9:0] idx, logic [10:0] len);
		int unsigned pk, tl, n, den, k, num;
		pk = peak_r;
		tl = (tail_r < peak_r) ? tail_r : peak_r;
		n = (len > MAX_PATH_POINTS) ? MAX_PATH_POINTS : len;
		if (n <= 1) begin
			return peak_r;
		end
		den = n - 1;
		k = (idx > den) ? den : idx;
		num = pk * den - k * (pk - tl);
		return 8'((2 * num + den) / (2 * den));
	endfunction

	// Apply one item to the cost map and return the result it should give
	function automatic stamp_rsp_t apply_item(stamp_req_t req);
		stamp_rsp_t res;
		int r, lx, ly, hx, hy, nx, ny;
		logic [7:0] c;
		res = '0;
		if (req.func == FUNC_READ) begin
			res.cell_cost = cost_map[int'(req.cell_y) * GRID_W + int'(req.cell_x)];
		end else if (en_r && req.in_map && req.path_length != 0) begin
			r = radius_r;
			if (r < 1) r = 1;
			if (r > MAX_RADIUS) r = MAX_RADIUS;
			lx = win_lo_x;
			ly = win_lo_y;
			hx = (win_hi_x > GRID_W) ? GRID_W : win_hi_x;
			hy = (win_hi_y > GRID_H) ? GRID_H : win_hi_y;
			c = path_point_cost(req.point_index, req.path_length);
			res.stamp_cost = c;
			for (int dx = -r; dx <= r; dx++) begin
				for (int dy = -r; dy <= r; dy++) begin
					nx = int'(req.cell_x) + dx;
					ny = int'(req.cell_y) + dy;
					if (dx * dx + dy * dy > r * r) continue;
					if (nx < lx || nx >= hx || ny < ly || ny >= hy) continue;
					if (nx < 0 || ny < 0) continue;
					if (cost_map[ny * GRID_W + nx] < c) cost_map[ny * GRID_W + nx] = c;
					res.cells_written = res.cells_written + 1'b1;
				end
			end
		end
		return res;
	endfunction

	function automatic stamp_req_t make_req(logic func, int x, int y, logic in_map, int idx,
			int len);
		stamp_req_t req;
		req.func        = func;
		req.cell_x      = x[7:0];
		req.cell_y      = y[7:0];
		req.in_map      = in_map;
		req.point_index = idx[9:0];
		req.path_length = len[10:0];
		return req;
	endfunction

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
	endfunction

	// Send one item, idling at random first, and predict its result on accept
	task automatic send_item(stamp_req_t req);
		stamp_rsp_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= req;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		res = apply_item(req);
		reports_due = {reports_due, res};
		n_sent++;
		if (req.func == FUNC_READ) n_reads++;
		else if (!en_r || !req.in_map || req.path_length == 0) n_skips++;
		else n_stamps++;
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (reports_due.size() != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [8:0] val);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx   <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_ENABLE:   en_r = val[0];
			REG_PEAK:     peak_r = val[7:0];
			REG_TAIL:     tail_r = val[7:0];
			REG_RADIUS:   radius_r = val[3:0];
			REG_WIN_LO_X: win_lo_x = val;
			REG_WIN_LO_Y: win_lo_y = val;
			REG_WIN_HI_X: win_hi_x = val;
			REG_WIN_HI_Y: win_hi_y = val;
			default: ;
		endcase
		n_cfg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic en, int pk, int tl, int rad, int lx, int ly, int hx, int hy);
		write_reg(REG_ENABLE, {8'd0, en});
		write_reg(REG_PEAK, pk[8:0]);
		write_reg(REG_TAIL, tl[8:0]);
		write_reg(REG_RADIUS, rad[8:0]);
		write_reg(REG_WIN_LO_X, lx[8:0]);
		write_reg(REG_WIN_LO_Y, ly[8:0]);
		write_reg(REG_WIN_HI_X, hx[8:0]);
		write_reg(REG_WIN_HI_Y, hy[8:0]);
	endtask

	// Random setting: small radius mostly, full window mostly
	task automatic pick_config();
		int rsel, wsel, pk, tl, rad, lx, ly, hx, hy;
		rsel = $urandom_range(19);
		wsel = $urandom_range(9);
		pk = ($urandom_range(4) == 0) ? 255 : $urandom_range(255);
		tl = ($urandom_range(4) == 0) ? 0 : $urandom_range(255);
		rad = (rsel == 0) ? 15 : (rsel == 1) ? 0 : $urandom_range(1, 4);
		lx = 0;
		ly = 0;
		hx = GRID_W;
		hy = GRID_H;
		if (wsel == 6) begin
			lx = $urandom_range(200);
			ly = $urandom_range(200);
			hx = $urandom_range(lx, 256);
			hy = $urandom_range(ly, 256);
		end else if (wsel == 7) begin
			hx = $urandom_range(257, 511);
			hy = $urandom_range(257, 511);
		end else if (wsel == 8) begin
			lx = $urandom_range(511);
			ly = $urandom_range(511);
			hx = $urandom_range(511);
			hy = $urandom_range(511);
		end else if (wsel == 9) begin
			hx = 511;
			hy = 511;
		end
		set_config($urandom_range(5) != 0, pk, tl, rad, lx, ly, hx, hy);
	endtask

	// Field extremes and path cases under the reset setting
	task automatic test_reset_edges();
		send_item(make_req(FUNC_READ, 0, 0, 1'b0, 0, 0));
		send_item(make_req(FUNC_READ, 255, 255, 1'b1, 1023, 2047));
		send_item(make_req(FUNC_STAMP, 0, 0, 1'b1, 0, 5));
		send_item(make_req(FUNC_STAMP, 255, 255, 1'b1, 4, 5));
		// path longer than the point limit, index at its last point
		send_item(make_req(FUNC_STAMP, 128, 64, 1'b1, 1023, 2047));
		send_item(make_req(FUNC_STAMP, 10, 10, 1'b1, 0, 1));
		send_item(make_req(FUNC_STAMP, 20, 20, 1'b1, 0, 0));
		send_item(make_req(FUNC_STAMP, 30, 30, 1'b0, 0, 5));
		send_item(make_req(FUNC_STAMP, 40, 40, 1'b1, 9, 3));
		send_item(make_req(FUNC_STAMP, 50, 50, 1'b1, 3, 8));
		send_item(make_req(FUNC_READ, 0, 0, 1'b0, 0, 0));
		send_item(make_req(FUNC_READ, 255, 255, 1'b0, 0, 0));
		send_item(make_req(FUNC_READ, 20, 20, 1'b0, 0, 0));
		send_item(make_req(FUNC_READ, 1, 0, 1'b0, 0, 0));
	endtask

	// Enable, cost clamps, radius bounds and window clipping
	task automatic test_register_cases();
		set_config(1'b0, 200, 80, 1, 0, 0, 256, 256);
		send_item(make_req(FUNC_STAMP, 60, 60, 1'b1, 0, 4));
		send_item(make_req(FUNC_READ, 60, 60, 1'b0, 0, 0));
		// half-up rounding at full radius
		set_config(1'b1, 255, 0, 15, 0, 0, 256, 256);
		send_item(make_req(FUNC_STAMP, 128, 128, 1'b1, 1, 3));
		send_item(make_req(FUNC_READ, 143, 128, 1'b0, 0, 0));
		// tail above peak, radius zero
		set_config(1'b1, 10, 200, 0, 0, 0, 256, 256);
		send_item(make_req(FUNC_STAMP, 5, 200, 1'b1, 2, 3));
		// window past the grid and empty
		set_config(1'b1, 255, 0, 15, 256, 256, 511, 511);
		send_item(make_req(FUNC_STAMP, 255, 0, 1'b1, 0, 2));
		set_config(1'b1, 255, 0, 15, 100, 0, 50, 256);
		send_item(make_req(FUNC_STAMP, 75, 10, 1'b1, 0, 2));
		// narrow window clips the disc
		set_config(1'b1, 255, 0, 15, 120, 120, 130, 125);
		send_item(make_req(FUNC_STAMP, 125, 122, 1'b1, 0, 2));
		send_item(make_req(FUNC_READ, 129, 124, 1'b0, 0, 0));
		send_item(make_req(FUNC_READ, 130, 124, 1'b0, 0, 0));
		set_config(1'b1, 0, 255, 2, 0, 0, 0, 0);
		send_item(make_req(FUNC_STAMP, 0, 0, 1'b1, 0, 2));
	endtask

	// Mostly well-formed paths with reads nearby, plus noise and broken paths
	task automatic test_random_paths(int n_items);
		int first, setup_end, kind, len, pts, r, idx;
		first = n_sent;
		while (n_sent - first < n_items) begin
			pick_config();
			setup_end = n_sent + ITEMS_PER_SETUP;
			while (n_sent < setup_end && n_sent - first < n_items) begin
				kind = $urandom_range(99);
				r = (radius_r == 0) ? 1 : radius_r;
				if (kind < 70) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(13, 1024) : $urandom_range(1, 12);
					pts = (len > 12) ? $urandom_range(3, 8) : len;
					last_x = 8'($urandom);
					last_y = 8'($urandom);
					for (int k = 0; k < pts; k++) begin
						if (len <= 12) idx = k;
						else if (k == pts - 1) idx = len - 1;
						else idx = (k * len) / pts + $urandom_range(len / pts - 1);
						send_item(make_req(FUNC_STAMP, last_x, last_y, $urandom_range(11) != 0,
							idx, len));
						if ($urandom_range(2) == 0) begin
							send_item(make_req(FUNC_READ, last_x + $urandom_range(2 * r + 2) - (r + 1),
								last_y + $urandom_range(2 * r + 2) - (r + 1), 1'($urandom_range(1)),
								$urandom_range(1023), $urandom_range(2047)));
						end
						last_x = 8'(last_x + $urandom_range(4) - 2);
						last_y = 8'(last_y + $urandom_range(4) - 2);
					end
				end else if (kind < 85) begin
					send_item(make_req(FUNC_READ, last_x + $urandom_range(2 * r + 2) - (r + 1),
						last_y + $urandom_range(2 * r + 2) - (r + 1), 1'b0, 0, 0));
				end else if (kind < 93) begin
					send_item(make_req(1'($urandom_range(1)), $urandom_range(255),
						$urandom_range(255), 1'($urandom_range(1)), $urandom_range(1023),
						$urandom_range(2047)));
				end else begin
					// broken path: empty length or indexes past a short path
					send_item(make_req(FUNC_STAMP, last_x, last_y, 1'b1, $urandom_range(1023), 0));
					send_item(make_req(FUNC_STAMP, last_x + 1, last_y, 1'($urandom_range(1)),
						$urandom_range(1023), $urandom_range(1, 3)));
				end
				if ($urandom_range(24) == 0) wait_idle();
			end
		end
	endtask

	// Receive side: random back-pressure, compare each result with the oldest prediction
	always @(posedge clk) begin
		stamp_rsp_t want;
		stamp_rsp_t got;
		got = rsp_ch.data;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (reports_due.size() == 0) begin
				note_fail($sformatf("result with none outstanding: cost %0d cells %0d read %0d",
					got.stamp_cost, got.cells_written, got.cell_cost));
			end else begin
				want = reports_due.pop_front();
				n_checked++;
				if (got.stamp_cost !== want.stamp_cost)
					note_fail($sformatf("stamp_cost exp %0d got %0d", want.stamp_cost, got.stamp_cost));
				if (got.cells_written !== want.cells_written)
					note_fail($sformatf("cells_written exp %0d got %0d", want.cells_written,
						got.cells_written));
				if (got.cell_cost !== want.cell_cost)
					note_fail($sformatf("cell_cost exp %0d got %0d", want.cell_cost, got.cell_cost));
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Watchdog: end the run when no channel moves for too long
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				STALL_LIMIT, reports_due.size());
			$display("[path_disc_cost_stamper] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx   = '0;
		cfg_ch.wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_edges();
		test_register_cases();
		src_idle_pct = 37;
		snk_idle_pct = 67;
		test_random_paths(ITEMS_PER_PHASE);
		src_idle_pct = 67;
		snk_idle_pct = 37;
		test_random_paths(ITEMS_PER_PHASE);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_paths(ITEMS_PER_PHASE);

		// drain, then watch for stray results
		wait_idle();
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		if (reports_due.size() != 0) note_fail($sformatf("%0d results never arrived",
			reports_due.size()));

		$display("covered %0d items: %0d stamps, %0d skipped stamps, %0d reads",
			n_sent, n_stamps, n_skips, n_reads);
		$display("%0d results checked over %0d register writes, %0d mismatches",
			n_checked, n_cfg_writes, n_fail);
		if (n_fail == 0) begin
			$display("[path_disc_cost_stamper] OK");
		end else begin
			$display("[path_disc_cost_stamper] ERROR");
		end
		$finish;
	end

endmodule
